### rtl/igbc_pkg.sv
// Shared types and constants of the int8 GEMM bias/clamp tile.
// No dependencies; imported by igbc_mac, igbc_clamp, the top level and tb_top.
package igbc_pkg;

   localparam int ACC_W        = 32;
   localparam int OP_W         = 8;
   localparam int PROD_W       = 2 * OP_W;
   localparam int ROW_W        = 2;
   localparam int COL_W        = 4;
   localparam int IDX_W        = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int ROWS_DEFAULT = 4;
   localparam int COLS_DEFAULT = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LO_BOUND    = 2'd0,
      CSR_HI_BOUND    = 2'd1,
      CSR_BIAS_ENABLE = 2'd2
   } csr_index_type;

   // finished sum on its way to the clamp stage
   typedef struct packed {
      logic [ACC_W-1:0] sum;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } sum_item_type;

endpackage

### rtl/igbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module igbc_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/igbc_mac.sv
// Accumulator read-modify-write: operand product, RAM read, forwarding, write-back.
// Depends on igbc_pkg and igbc_ram.
module igbc_mac #(
   parameter int ROWS = igbc_pkg::ROWS_DEFAULT,
   parameter int COLS = igbc_pkg::COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [igbc_pkg::ROW_W-1:0]        req_row,
   input  logic [igbc_pkg::COL_W-1:0]        req_col,
   input  logic signed [igbc_pkg::OP_W-1:0]  req_a_value,
   input  logic signed [igbc_pkg::OP_W-1:0]  req_b_value,
   input  logic signed [igbc_pkg::ACC_W-1:0] req_bias,
   input  logic                              req_first_k,
   input  logic                              req_last_k,
   input  logic                              bias_enable,
   input  logic                              sum_ready,
   output logic                              sum_valid,
   output igbc_pkg::sum_item_type            sum_item
);
   import igbc_pkg::*;

   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [ACC_W-1:0]  s1_base_ff;
   logic              s1_first_ff;
   logic              s1_last_ff;
   logic              fwd_ff;
   logic [ACC_W-1:0]  fwd_data_ff;

   logic [IDX_W-1:0]  idx_full;
   logic [ADDR_W-1:0] addr;
   logic              in_range;
   logic              s1_adv;
   logic              take;
   logic [ACC_W-1:0]  rd_data;
   logic [ACC_W-1:0]  prior;
   logic [ACC_W-1:0]  acc_new;
   logic              wr_en;
   logic              fwd_in;

   assign idx_full = IDX_W'(req_row) * IDX_W'(COLS) + IDX_W'(req_col);
   assign addr     = idx_full[ADDR_W-1:0];
   assign in_range = (int'(req_row) < ROWS) && (int'(req_col) < COLS);

   assign s1_adv    = !s1_valid_ff || !s1_last_ff || sum_ready;
   assign req_ready = s1_adv;
   assign take      = req_valid && req_ready && in_range;

   assign prior   = fwd_ff ? fwd_data_ff : rd_data;
   assign acc_new = (s1_first_ff ? s1_base_ff : prior)
                  + {{(ACC_W-PROD_W){s1_prod_ff[PROD_W-1]}}, s1_prod_ff};
   assign wr_en   = s1_valid_ff && s1_adv;
   assign fwd_in  = wr_en && (s1_addr_ff == addr);

   igbc_ram #(
      .WIDTH (ACC_W),
      .DEPTH (DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (acc_new),
      .rd_en   (take),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_addr_ff  <= addr;
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_col;
         s1_prod_ff  <= PROD_W'(req_a_value) * PROD_W'(req_b_value);
         s1_base_ff  <= bias_enable ? req_bias : '0;
         s1_first_ff <= req_first_k;
         s1_last_ff  <= req_last_k;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= acc_new;
      end
   end

   assign sum_valid    = s1_valid_ff && s1_last_ff;
   assign sum_item.sum = acc_new;
   assign sum_item.row = s1_row_ff;
   assign sum_item.col = s1_col_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stalled accumulator stage lost its item");

   a_drop_outside: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !in_range |=> !s1_valid_ff)
      else $error("item outside the tile entered the pipeline");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && fwd_ff && $past(take)
      |-> $past(wr_en) && ($past(s1_addr_ff) == s1_addr_ff))
      else $error("forwarded data without a matching write");

endmodule

### rtl/igbc_clamp.sv
// Sum register, clamp to the lower and upper bound and result output register.
// Depends on igbc_pkg.
module igbc_clamp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sum_valid,
   output logic                              sum_ready,
   input  igbc_pkg::sum_item_type            sum_item,
   input  logic signed [igbc_pkg::ACC_W-1:0] lo_bound,
   input  logic signed [igbc_pkg::ACC_W-1:0] hi_bound,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [igbc_pkg::ACC_W-1:0] rsp_d_value,
   output logic [igbc_pkg::ROW_W-1:0]        rsp_out_row,
   output logic [igbc_pkg::COL_W-1:0]        rsp_out_col
);
   import igbc_pkg::*;

   logic                    s2_valid_ff;
   sum_item_type            s2_item_ff;
   logic                    out_valid_ff;
   logic signed [ACC_W-1:0] out_d_ff;
   logic [ROW_W-1:0]        out_row_ff;
   logic [COL_W-1:0]        out_col_ff;

   logic                    out_free;
   logic                    s2_free;
   logic signed [ACC_W-1:0] raised;
   logic signed [ACC_W-1:0] clamped_in;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign sum_ready = s2_free;

   assign raised     = ($signed(s2_item_ff.sum) < lo_bound) ? lo_bound
                                                            : $signed(s2_item_ff.sum);
   assign clamped_in = (raised > hi_bound) ? hi_bound : raised;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_valid_ff <= sum_valid;
         end
         if (out_free) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && sum_valid) begin
         s2_item_ff <= sum_item;
      end
      if (out_free && s2_valid_ff) begin
         out_d_ff   <= clamped_in;
         out_row_ff <= s2_item_ff.row;
         out_col_ff <= s2_item_ff.col;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_d_value = out_d_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_item_ff))
      else $error("sum stage overwritten while output blocked");

   a_s2_feeds_out: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && out_free |=> out_valid_ff)
      else $error("sum item not moved to the output register");

endmodule

### rtl/int8_gemm_bias_clamp_tile.sv
// Top level of the int8 GEMM bias/clamp tile: configuration registers and pipeline.
// Depends on igbc_pkg, igbc_mac, igbc_clamp (and igbc_ram below igbc_mac).
//
// Accumulates D = clamp(C + A*B) for a ROWS x COLS tile held in one accumulator RAM
// (one read and one write port). One item is taken per cycle: the entry is read
// on acceptance, product added and written back when it leaves s1, with the
// write-stage value forwarded when the next item hits the same entry. A last_k
// item presents its result on rsp_valid after the s1, sum and output registers;
// items without last_k or outside the tile give none. The block only stalls when
// a finished result cannot move on because the result side holds rsp_ready low.
// Entries are undefined after reset until an item with first_k starts them. Write
// the lower bound, the upper bound and bias_enable only while no item is in flight.
module int8_gemm_bias_clamp_tile #(
   parameter int ROWS = igbc_pkg::ROWS_DEFAULT,
   parameter int COLS = igbc_pkg::COLS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [igbc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [igbc_pkg::ACC_W-1:0]            csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [igbc_pkg::ROW_W-1:0]            req_row,
   input  logic [igbc_pkg::COL_W-1:0]            req_col,
   input  logic signed [igbc_pkg::OP_W-1:0]      req_a_value,
   input  logic signed [igbc_pkg::OP_W-1:0]      req_b_value,
   input  logic signed [igbc_pkg::ACC_W-1:0]     req_bias,
   input  logic                                  req_first_k,
   input  logic                                  req_last_k,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [igbc_pkg::ACC_W-1:0]     rsp_d_value,
   output logic [igbc_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [igbc_pkg::COL_W-1:0]            rsp_out_col
);
   import igbc_pkg::*;

   logic signed [ACC_W-1:0] lo_bound_ff;
   logic signed [ACC_W-1:0] hi_bound_ff;
   logic                    bias_enable_ff;

   logic                    sum_valid;
   logic                    sum_ready;
   sum_item_type            sum_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_bound_ff    <= {1'b1, {(ACC_W-1){1'b0}}};
         hi_bound_ff    <= {1'b0, {(ACC_W-1){1'b1}}};
         bias_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LO_BOUND:    lo_bound_ff    <= csr_wdata;
            CSR_HI_BOUND:    hi_bound_ff    <= csr_wdata;
            CSR_BIAS_ENABLE: bias_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   igbc_mac #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .req_bias    (req_bias),
      .req_first_k (req_first_k),
      .req_last_k  (req_last_k),
      .bias_enable (bias_enable_ff),
      .sum_ready   (sum_ready),
      .sum_valid   (sum_valid),
      .sum_item    (sum_item)
   );

   igbc_clamp u_clamp (
      .clock       (clock),
      .reset       (reset),
      .sum_valid   (sum_valid),
      .sum_ready   (sum_ready),
      .sum_item    (sum_item),
      .lo_bound    (lo_bound_ff),
      .hi_bound    (hi_bound_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_d_value (rsp_d_value),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col)
   );

endmodule

### verif/tb_top.sv
// Self-checking testbench for int8_gemm_bias_clamp_tile: directed and random MAC streams
// checked against a local tile predictor. Depends on rtl/igbc_pkg.sv and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
   import igbc_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TILE_ENTRIES = ROWS_DEFAULT * COLS_DEFAULT;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [OP_W-1:0]  a;
      logic signed [OP_W-1:0]  b;
      logic signed [ACC_W-1:0] bias;
      logic                    first;
      logic                    last;
   } mac_item_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] d;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
   } d_elem_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = CSR_LO_BOUND;
   logic [ACC_W-1:0]             csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [ROW_W-1:0]             req_row = '0;
   logic [COL_W-1:0]             req_col = '0;
   logic signed [OP_W-1:0]       req_a_value = '0;
   logic signed [OP_W-1:0]       req_b_value = '0;
   logic signed [ACC_W-1:0]      req_bias = '0;
   logic                         req_first_k = 1'b0;
   logic                         req_last_k = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]      rsp_d_value;
   logic [ROW_W-1:0]             rsp_out_row;
   logic [COL_W-1:0]             rsp_out_col;

   // predictor state
   logic [ACC_W-1:0]        acc_model [TILE_ENTRIES];
   bit                      started [TILE_ENTRIES];
   logic signed [ACC_W-1:0] lo_bound;
   logic signed [ACC_W-1:0] hi_bound;
   logic                    bias_on;
   d_elem_type              d_due [$];

   // random stream lanes: each runs one well-formed k sequence on one entry
   int      lane_entry [4];
   int      lane_left [4];

   bit      req_idle_on = 1'b0;
   bit      rsp_idle_on = 1'b0;
   int      rsp_hold = 0;
   int      hold_next;
   int      quiet_cycles = 0;
   int      mismatch_count = 0;
   d_elem_type d_want;

   int8_gemm_bias_clamp_tile uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .req_bias    (req_bias),
      .req_first_k (req_first_k),
      .req_last_k  (req_last_k),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_d_value (rsp_d_value),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col)
   );

   always #5 clock = ~clock;

   function automatic void mac_tile_step(input mac_item_type it);
      int                      idx;
      logic signed [PROD_W-1:0] prod;
      logic [ACC_W-1:0]        acc;
      logic signed [ACC_W-1:0] sum;
      d_elem_type              r;
      idx = it.row * COLS_DEFAULT + it.col;
      prod = it.a * it.b;
      if (it.first) begin
         acc = bias_on ? it.bias : '0;
         started[idx] = 1'b1;
      end else begin
         acc = acc_model[idx];
      end
      acc = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      acc_model[idx] = acc;
      if (it.last) begin
         sum = acc;
         if (sum < lo_bound) sum = lo_bound;
         if (sum > hi_bound) sum = hi_bound;
         r.d = sum;
         r.row = it.row;
         r.col = it.col;
         d_due.push_back(r);
      end
   endfunction

   function automatic logic signed [OP_W-1:0] rand_operand();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
      return OP_W'($urandom);
   endfunction

   function automatic mac_item_type next_mac_item();
      mac_item_type it;
      int        lane;
      int        e;
      it.a = rand_operand();
      it.b = rand_operand();
      if ($urandom_range(0, 7) == 0)
         it.bias = $urandom_range(0, 1) ? ACC_MAX : ACC_MIN;
      else
         it.bias = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any entry, loose flags, but never an unstarted read
         e = $urandom_range(0, TILE_ENTRIES - 1);
         it.first = !started[e] || ($urandom_range(0, 3) == 0);
         it.last = 1'($urandom_range(0, 1));
      end else begin
         lane = $urandom_range(0, 3);
         if (lane_left[lane] == 0) begin
            lane_entry[lane] = $urandom_range(0, TILE_ENTRIES - 1);
            lane_left[lane] = $urandom_range(1, 12);
            it.first = 1'b1;
         end else begin
            it.first = 1'b0;
         end
         it.last = (lane_left[lane] == 1);
         lane_left[lane]--;
         e = lane_entry[lane];
      end
      it.row = ROW_W'(e / COLS_DEFAULT);
      it.col = COL_W'(e % COLS_DEFAULT);
      return it;
   endfunction

   task automatic send_mac(input mac_item_type it);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row <= it.row;
      req_col <= it.col;
      req_a_value <= it.a;
      req_b_value <= it.b;
      req_bias <= it.bias;
      req_first_k <= it.first;
      req_last_k <= it.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mac_tile_step(it);
   endtask

   task automatic send_fields(input int row, input int col, input int a, input int b,
                              input logic [ACC_W-1:0] bias, input bit first, input bit last);
      mac_item_type it;
      it.row = ROW_W'(row);
      it.col = COL_W'(col);
      it.a = OP_W'(a);
      it.b = OP_W'(b);
      it.bias = bias;
      it.first = first;
      it.last = last;
      send_mac(it);
   endtask

   // stop sending, wait for every result, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (d_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_tile_cfg(input logic signed [ACC_W-1:0] lo,
                               input logic signed [ACC_W-1:0] hi, input logic en);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LO_BOUND;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_HI_BOUND;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_BIAS_ENABLE;
      csr_wdata <= {{(ACC_W-1){1'b0}}, en};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lo_bound = lo;
      hi_bound = hi;
      bias_on = en;
   endtask

   task automatic test_operand_extremes();
      settle();
      set_tile_cfg(ACC_MIN, ACC_MAX, 1'b0);
      send_fields(0, 0, -128, -128, ACC_MAX, 1, 1);
      send_fields(3, 15, 127, 127, ACC_MIN, 1, 0);
      send_fields(3, 15, -128, 127, 0, 0, 0);
      send_fields(3, 15, 127, -128, 0, 0, 1);
      send_fields(2, 9, 0, -1, 32'hffff_ffff, 1, 1);
      send_fields(1, 6, -1, -1, 0, 1, 0);
      send_fields(1, 6, 8'h55, 8'haa, 0, 0, 0);
      send_fields(1, 6, 8'haa, 8'h55, 0, 0, 1);
   endtask

   task automatic test_bias_wrap();
      settle();
      set_tile_cfg(ACC_MIN, ACC_MAX, 1'b1);
      send_fields(0, 1, 127, 127, ACC_MAX, 1, 1);
      send_fields(0, 2, -128, 127, ACC_MIN, 1, 1);
      send_fields(1, 1, 1, 1, 32'h1234_5678, 1, 0);
      send_fields(1, 1, 2, 3, 32'hffff_ffff, 0, 1);
      send_fields(2, 2, 0, 0, 32'hffff_ffff, 1, 1);
   endtask

   task automatic test_clamp_bounds();
      settle();
      set_tile_cfg(-32'sd100, 32'sd100, 1'b0);
      send_fields(0, 3, 127, 127, 0, 1, 1);
      send_fields(0, 3, -128, 127, 0, 1, 1);
      send_fields(0, 3, 5, 5, 0, 1, 1);
      settle();
      // crossed bounds: everything lands on the upper bound
      set_tile_cfg(32'sd50, -32'sd50, 1'b1);
      send_fields(0, 4, 0, 0, -32'sd1000, 1, 1);
      send_fields(0, 4, 1, 1, 32'sd1000, 1, 1);
   endtask

   task automatic test_pause_until_drained();
      settle();
      set_tile_cfg(-32'sd50000, 32'sd50000, 1'b1);
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      repeat (60) send_mac(next_mac_item());
      settle();
      repeat (60) send_mac(next_mac_item());
   endtask

   task automatic test_random_tiles();
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] hi;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case (phase % 4)
            0: begin
               lo = ACC_MIN;
               hi = ACC_MAX;
            end
            1: begin
               lo = -$signed(ACC_W'($urandom_range(0, 300000)));
               hi = $signed(ACC_W'($urandom_range(0, 300000)));
            end
            2: begin
               lo = $urandom;
               hi = $urandom;
            end
            default: begin
               lo = -$signed(ACC_W'($urandom_range(0, 100000)));
               hi = lo + $signed(ACC_W'($urandom_range(0, 50000)));
            end
         endcase
         set_tile_cfg(lo, hi, phase == 5 ? 1'b1 : 1'($urandom_range(0, 1)));
         req_idle_on = (phase != 0) && (phase != 3);
         rsp_idle_on <= (phase != 0) && (phase != 4);
         repeat (200) send_mac(next_mac_item());
      end
   endtask

   // result side: random stall per item, then check against oldest due result
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (d_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none due: d %0d row %0d col %0d",
                        $time, rsp_d_value, rsp_out_row, rsp_out_col);
            end else begin
               d_want = d_due.pop_front();
               if (rsp_d_value !== d_want.d) begin
                  mismatch_count++;
                  $display("%0t: d_value expected %0d actual %0d",
                           $time, d_want.d, rsp_d_value);
               end
               if (rsp_out_row !== d_want.row) begin
                  mismatch_count++;
                  $display("%0t: out_row expected %0d actual %0d",
                           $time, d_want.row, rsp_out_row);
               end
               if (rsp_out_col !== d_want.col) begin
                  mismatch_count++;
                  $display("%0t: out_col expected %0d actual %0d",
                           $time, d_want.col, rsp_out_col);
               end
            end
            hold_next = rsp_idle_on ? $urandom_range(0, 11) : 0;
         end else begin
            hold_next = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         end
         rsp_hold <= hold_next;
         rsp_ready <= (hold_next == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      lo_bound = ACC_MIN;
      hi_bound = ACC_MAX;
      bias_on = 1'b0;
      for (int i = 0; i < 4; i++) begin
         lane_entry[i] = 0;
         lane_left[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_operand_extremes();
      test_bias_wrap();
      test_clamp_bounds();
      test_pause_until_drained();
      test_random_tiles();
      settle();
      if (mismatch_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

### int8_gemm_bias_clamp_tile.f
rtl/igbc_pkg.sv
rtl/igbc_ram.sv
rtl/igbc_mac.sv
rtl/igbc_clamp.sv
rtl/int8_gemm_bias_clamp_tile.sv
verif/tb_top.sv
